// File: src/skbs_pkg.sv
`timescale 1ns / 1ps

package skbs_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 32;
    localparam int IDX_W       = 7;

    typedef enum logic [0:0] {
        REQ_APPEND = 1'b0,
        REQ_SEARCH = 1'b1
    } t_req_type;

    typedef enum logic [1:0] {
        ST_APPENDED  = 2'd0,
        ST_FULL      = 2'd1,
        ST_FOUND     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE  = 2'd0,
        S_PROBE = 2'd1,
        S_DONE  = 2'd2
    } t_state;

    typedef struct packed {
        t_req_type          req_type;
        logic signed [31:0] key;
    } t_request;

    typedef struct packed {
        t_status    status;
        logic [6:0] index;
    } t_result;

endpackage

// File: src/sorted_key_table_binary_search.sv
`timescale 1ns / 1ps

// channel   | valid    | ready    | payload
// ----------+----------+----------+--------------------------------
// request   | i_valid  | o_ready  | i_req (req_type, key)
// result    | o_valid  | i_ready  | o_res (status, index)
//
// an append writes the key memory in the accept cycle, and the done state
// loads the result register once that register is free. a search issues its
// first read in the accept cycle; each probe then checks the registered read
// of the key memory and issues the next read (at most log2(depth)+1 probes, 8
// at depth 128), and the done state loads the result. one request is in flight
// at a time. the result register holds while i_ready is low; a new request is
// taken meanwhile and only its result load waits. reset clears the entry count.

module sorted_key_table_binary_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  skbs_pkg::t_request i_req,
    output logic               o_valid,
    input  logic               i_ready,
    output skbs_pkg::t_result  o_res
);

    skbs_pkg::t_state r_state;
    skbs_pkg::t_state n_state;

    logic [skbs_pkg::CNT_W-1:0]  r_count;
    logic [skbs_pkg::CNT_W-1:0]  n_count;
    logic [skbs_pkg::CNT_W-1:0]  r_left;
    logic [skbs_pkg::CNT_W-1:0]  n_left;
    logic [skbs_pkg::CNT_W-1:0]  r_end;
    logic [skbs_pkg::CNT_W-1:0]  n_end;
    logic [skbs_pkg::ADDR_W-1:0] r_mid;
    logic [skbs_pkg::ADDR_W-1:0] n_mid;
    logic signed [31:0]          r_key;
    logic signed [31:0]          n_key;
    skbs_pkg::t_status           r_status;
    skbs_pkg::t_status           n_status;
    logic [skbs_pkg::ADDR_W-1:0] r_slot;
    logic [skbs_pkg::ADDR_W-1:0] n_slot;
    logic                        r_valid;
    logic                        n_valid;
    skbs_pkg::t_result           r_res;
    skbs_pkg::t_result           n_res;

    logic                        w_accept;
    logic                        w_not_full;
    logic                        w_we;
    logic [skbs_pkg::ADDR_W-1:0] w_raddr;
    logic [31:0]                 w_rdata;
    logic signed [31:0]          w_probe;
    logic [skbs_pkg::CNT_W-1:0]  w_mid_ext;
    logic [skbs_pkg::CNT_W-1:0]  w_nl;
    logic [skbs_pkg::CNT_W-1:0]  w_ne;
    logic [skbs_pkg::CNT_W:0]    w_sum;
    logic [skbs_pkg::CNT_W:0]    w_sum0;
    logic                        w_out_free;

    skbs_ram #(
        .WIDTH(skbs_pkg::KEY_W),
        .DEPTH(skbs_pkg::TABLE_DEPTH)
    ) u_keys (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(r_count[skbs_pkg::ADDR_W-1:0]),
        .i_wdata(i_req.key),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_accept   = i_valid && o_ready;
    assign w_not_full = r_count < skbs_pkg::CNT_W'(skbs_pkg::TABLE_DEPTH);
    assign w_probe    = $signed(w_rdata);
    assign w_mid_ext  = skbs_pkg::CNT_W'(r_mid);
    assign w_out_free = !r_valid || i_ready;
    assign w_sum0     = {1'b0, r_count} - (skbs_pkg::CNT_W + 1)'(1);

    // narrow the search range around the probed slot
    always_comb begin
        if (w_probe < r_key) begin
            w_nl = w_mid_ext + skbs_pkg::CNT_W'(1);
            w_ne = r_end;
        end else begin
            w_nl = r_left;
            w_ne = w_mid_ext;
        end
        w_sum = {1'b0, w_nl} + {1'b0, w_ne} - (skbs_pkg::CNT_W + 1)'(1);
    end

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_left   = r_left;
        n_end    = r_end;
        n_mid    = r_mid;
        n_key    = r_key;
        n_status = r_status;
        n_slot   = r_slot;
        n_valid  = r_valid && !i_ready;
        n_res    = r_res;
        case (r_state)
            skbs_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_key = i_req.key;
                    if (i_req.req_type == skbs_pkg::REQ_APPEND) begin
                        n_state = skbs_pkg::S_DONE;
                        n_slot  = r_count[skbs_pkg::ADDR_W-1:0];
                        if (w_not_full) begin
                            n_count  = r_count + skbs_pkg::CNT_W'(1);
                            n_status = skbs_pkg::ST_APPENDED;
                        end else begin
                            n_status = skbs_pkg::ST_FULL;
                        end
                    end else if (r_count == '0) begin
                        n_state  = skbs_pkg::S_DONE;
                        n_status = skbs_pkg::ST_NOT_FOUND;
                    end else begin
                        n_state = skbs_pkg::S_PROBE;
                        n_left  = '0;
                        n_end   = r_count;
                        n_mid   = w_sum0[skbs_pkg::ADDR_W:1];
                    end
                end
            end
            skbs_pkg::S_PROBE: begin
                if (w_probe == r_key) begin
                    n_state  = skbs_pkg::S_DONE;
                    n_status = skbs_pkg::ST_FOUND;
                    n_slot   = r_mid;
                end else if (w_nl < w_ne) begin
                    n_left = w_nl;
                    n_end  = w_ne;
                    n_mid  = w_sum[skbs_pkg::ADDR_W:1];
                end else begin
                    n_state  = skbs_pkg::S_DONE;
                    n_status = skbs_pkg::ST_NOT_FOUND;
                end
            end
            skbs_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state      = skbs_pkg::S_IDLE;
                    n_valid      = 1'b1;
                    n_res.status = r_status;
                    if (r_status == skbs_pkg::ST_APPENDED || r_status == skbs_pkg::ST_FOUND) begin
                        n_res.index = skbs_pkg::IDX_W'(r_slot);
                    end else begin
                        n_res.index = '0;
                    end
                end
            end
            default: begin
                n_state = skbs_pkg::S_IDLE;
            end
        endcase
    end

    // outputs and memory control
    always_comb begin
        o_ready = 1'b0;
        w_we    = 1'b0;
        w_raddr = r_mid;
        case (r_state)
            skbs_pkg::S_IDLE: begin
                o_ready = 1'b1;
                w_we    = i_valid && i_req.req_type == skbs_pkg::REQ_APPEND && w_not_full;
                w_raddr = w_sum0[skbs_pkg::ADDR_W:1];
            end
            skbs_pkg::S_PROBE: begin
                w_raddr = w_sum[skbs_pkg::ADDR_W:1];
            end
            default: begin
                w_raddr = r_mid;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= skbs_pkg::S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
        r_left   <= n_left;
        r_end    <= n_end;
        r_mid    <= n_mid;
        r_key    <= n_key;
        r_status <= n_status;
        r_slot   <= n_slot;
        r_res    <= n_res;
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

`ifndef SYNTH
    a_probe_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == skbs_pkg::S_PROBE |-> (r_left <= w_mid_ext && w_mid_ext < r_end))
        else $error("probe slot outside search range");

    a_range_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == skbs_pkg::S_PROBE |-> r_end <= r_count)
        else $error("search range beyond filled entries");

    a_append_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.req_type == skbs_pkg::REQ_APPEND && w_not_full)
        |=> r_count == $past(r_count) + skbs_pkg::CNT_W'(1))
        else $error("append did not advance entry count");
`endif

endmodule

// File: src/skbs_ram.sv
`timescale 1ns / 1ps

module skbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: tb/sv/skbs_answer_checker.sv
`timescale 1ns / 1ps

module skbs_answer_checker
    import skbs_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_req_valid,
    input  logic     i_req_ready,
    input  t_request i_req,
    input  logic     i_res_valid,
    input  logic     i_res_ready,
    input  t_result  i_res,
    output int       o_fail_count,
    output int       o_pending
);

    logic signed [KEY_W-1:0] stored_keys [TABLE_DEPTH];
    int                      stored_count = 0;
    t_result                 awaited_answers [$];
    int                      mismatches = 0;

    // applies one request to the shadow table and works out its answer
    task automatic answer_request(input t_request rq, output t_result ans);
        int lo;
        int hi;
        int mid;
        ans.status = ST_NOT_FOUND;
        ans.index  = '0;
        if (rq.req_type == REQ_APPEND) begin
            if (stored_count < TABLE_DEPTH) begin
                stored_keys[stored_count] = rq.key;
                ans.status   = ST_APPENDED;
                ans.index    = IDX_W'(stored_count);
                stored_count = stored_count + 1;
            end else begin
                ans.status = ST_FULL;
            end
        end else begin
            lo = 0;
            hi = stored_count - 1;
            while (lo <= hi) begin
                mid = (lo + hi) / 2;
                if (stored_keys[mid] == $signed(rq.key)) begin
                    ans.status = ST_FOUND;
                    ans.index  = IDX_W'(mid);
                    break;
                end
                if ($signed(stored_keys[mid]) < $signed(rq.key)) begin
                    lo = mid + 1;
                end else begin
                    hi = mid - 1;
                end
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;
        t_result got;
        if (!i_rst_n) begin
            stored_count = 0;
            awaited_answers.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                got = i_res;
                if (awaited_answers.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d index %0d",
                             $time, got.status, got.index);
                    mismatches++;
                end else begin
                    want = awaited_answers.pop_front();
                    if (got.status !== want.status) begin
                        $display("%0t: status mismatch, expected %0d, got %0d",
                                 $time, want.status, got.status);
                        mismatches++;
                    end
                    if (got.index !== want.index) begin
                        $display("%0t: index mismatch, expected %0d, got %0d",
                                 $time, want.index, got.index);
                        mismatches++;
                    end
                end
            end
            if (i_req_valid && i_req_ready) begin
                answer_request(i_req, want);
                awaited_answers.push_back(want);
            end
        end
        o_fail_count <= mismatches;
        o_pending    <= awaited_answers.size();
    end

endmodule

// File: tb/sv/tb_sorted_key_table_binary_search.sv
`timescale 1ns / 1ps

module tb_sorted_key_table_binary_search;
    import skbs_pkg::*;

    localparam int                      QUIET_LIMIT     = 1000;
    localparam int                      RANDOM_REQUESTS = 400;
    localparam logic signed [KEY_W-1:0] KEY_MIN         = 32'sh8000_0000;
    localparam logic signed [KEY_W-1:0] KEY_MAX         = 32'sh7fff_ffff;

    logic     i_clk = 1'b0;
    logic     i_rst_n;
    logic     i_valid;
    logic     o_ready;
    t_request i_req;
    logic     o_valid;
    logic     i_ready;
    t_result  o_res;

    int                      fail_count;
    int                      pending;
    int                      quiet_cycles;
    bit                      sender_burst;
    bit                      receiver_burst;
    logic signed [KEY_W-1:0] appended_keys [$];
    logic signed [KEY_W-1:0] climb;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    sorted_key_table_binary_search dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_res   (o_res)
    );

    skbs_answer_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_valid),
        .i_req_ready  (o_ready),
        .i_req        (i_req),
        .i_res_valid  (o_valid),
        .i_res_ready  (i_ready),
        .i_res        (o_res),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    task automatic issue(input t_req_type kind, input logic signed [KEY_W-1:0] k);
        int gap;
        gap = sender_burst ? 0 : $urandom_range(0, 9);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= '{req_type: kind, key: k};
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        if (kind == REQ_APPEND && appended_keys.size() < TABLE_DEPTH) begin
            appended_keys.push_back(k);
        end
    endtask

    // keeps appends in ascending order, the last free slot gets the top key
    function automatic logic signed [KEY_W-1:0] next_ascending();
        longint nxt;
        if (appended_keys.size() == TABLE_DEPTH - 1) begin
            climb = KEY_MAX;
            return climb;
        end
        nxt = longint'(climb);
        if ($urandom_range(0, 15) != 0) begin
            nxt += $urandom_range(1, 1 << 25);
        end
        if (nxt > longint'(KEY_MAX)) begin
            nxt = KEY_MAX;
        end
        climb = nxt[KEY_W-1:0];
        return climb;
    endfunction

    // mostly stored keys, some neighbours of them, some anything
    function automatic logic signed [KEY_W-1:0] probe_key();
        logic signed [KEY_W-1:0] k;
        int                      pick;
        pick = $urandom_range(0, 99);
        if (appended_keys.size() == 0 || pick < 20) begin
            k = $urandom;
        end else begin
            k = appended_keys[$urandom_range(0, appended_keys.size() - 1)];
            if (pick >= 70) begin
                k = k + (pick[0] ? 1 : -1);
            end
        end
        return k;
    endfunction

    initial begin
        int                      n;
        int                      pick;
        logic signed [KEY_W-1:0] k;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_req        <= '0;
        sender_burst = 1'b0;
        climb        = 1;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty table, then extremes, duplicates and misses
        issue(REQ_SEARCH, 0);
        issue(REQ_APPEND, KEY_MIN);
        issue(REQ_APPEND, KEY_MIN);
        issue(REQ_APPEND, -1);
        issue(REQ_APPEND, 0);
        issue(REQ_APPEND, 1);
        issue(REQ_SEARCH, KEY_MIN);
        issue(REQ_SEARCH, -1);
        issue(REQ_SEARCH, 0);
        issue(REQ_SEARCH, 1);
        issue(REQ_SEARCH, KEY_MAX);
        issue(REQ_SEARCH, -2);
        issue(REQ_SEARCH, KEY_MIN + 1);
        issue(REQ_SEARCH, 2);

        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % 40 == 0) begin
                sender_burst = ($urandom_range(0, 3) == 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // the odd out-of-order key
                if (pick == 0 && appended_keys.size() != TABLE_DEPTH - 1) begin
                    k = $urandom;
                end else begin
                    k = next_ascending();
                end
                issue(REQ_APPEND, k);
            end else begin
                issue(REQ_SEARCH, probe_key());
            end
        end

        sender_burst = 1'b0;
        while (appended_keys.size() < TABLE_DEPTH) begin
            issue(REQ_APPEND, next_ascending());
        end
        issue(REQ_APPEND, KEY_MIN);
        issue(REQ_SEARCH, KEY_MAX);
        issue(REQ_SEARCH, KEY_MIN);
        i_valid <= 1'b0;

        do @(posedge i_clk); while (pending != 0);
        repeat (12) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("tb_sorted_key_table_binary_search: clean");
        end else begin
            $display("tb_sorted_key_table_binary_search: errors");
        end
        $finish;
    end

    initial begin
        int stall;
        int served;
        i_ready <= 1'b0;
        served  = 0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (served % 30 == 0) begin
                receiver_burst = ($urandom_range(0, 3) == 0);
            end
            stall = receiver_burst ? 0 : $urandom_range(0, 9);
            if (stall != 0) begin
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            served++;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("tb_sorted_key_table_binary_search: errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
